// File: hdl/polar_info_bit_mapper_core_macros.svh
// Assertion macros for the polar information bit mapper checker.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef POLAR_INFO_BIT_MAPPER_CORE_MACROS_SVH
`define POLAR_INFO_BIT_MAPPER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIBM_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("polar info bit mapper: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PIBM_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("polar info bit mapper: next-cycle check failed");

`endif

// File: hdl/pibm_pkg.sv
// Shared types and constants of the polar information bit mapper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pibm_pkg;

   localparam int WORD_BITS   = 64;
   localparam int CFG_W       = 11;
   localparam int REQ_TDATA_W = 72;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_INSERT  = 2'd1;
   localparam logic [1:0] OP_EXTRACT = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   localparam logic REG_CODE_LENGTH = 1'b0;
   localparam logic REG_INFO_BITS   = 1'b1;

   localparam logic RSP_KIND_WORD = 1'b0;
   localparam logic RSP_KIND_BYTE = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET_LENGTH = 11'd1024;
   localparam logic [CFG_W-1:0] CFG_RESET_INFO   = 11'd1024;

   typedef struct packed {
      logic                 valid;
      logic                 kind;
      logic [WORD_BITS-1:0] data;
      logic                 last;
   } rsp_emit_type;

endpackage

`default_nettype wire

// File: hdl/polar_info_bit_mapper_core.sv
// Polar information bit mapper: frozen-bit insertion and information-bit extraction.
// Top level; instantiates pibm_mask_store, pibm_bit_engine and pibm_out_reg; uses pibm_pkg.
//
// The block walks the codeword one position per cycle. A mask load or an unknown operation is
// taken in its accept cycle, and the next item can follow in the next cycle. An insert walks
// every codeword position it fills (its eight information bits plus every frozen position
// before or between them) and then closes the byte; the byte that completes the information
// block instead runs on through the rest of the codeword and then clears the block state. An
// extract walks from the current position to the next 64-bit boundary or the end of the
// codeword. A step that would emit a result waits while the output register holds a result
// that is not taken. The mask memory comes out of reset as all information positions through
// per-word valid bits, with no clearing pass.
`default_nettype none

module polar_info_bit_mapper_core #(
   parameter int MAX_LENGTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: word_index[3:0], payload[67:4], zero fill[71:68].
   input  logic [pibm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: operation[1:0].
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: result_data[63:0].
   output logic [pibm_pkg::WORD_BITS-1:0]   rsp_tdata,
   // Fields from bit 0: result_kind[0].
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [pibm_pkg::CFG_W-1:0]       csr_wdata
);
   import pibm_pkg::*;

   localparam int MASK_WORDS = MAX_LENGTH / WORD_BITS;
   localparam int AW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

   logic                 item_accept;
   logic                 load_en;
   logic [AW-1:0]        load_addr;
   logic [AW-1:0]        mask_addr;
   logic [WORD_BITS-1:0] mask_word;
   logic                 out_busy;
   logic                 engine_idle;
   rsp_emit_type         emit;

   assign item_accept = req_tvalid && req_tready;
   assign load_en     = item_accept && (req_tuser == OP_LOAD)
                        && (int'(req_tdata[3:0]) < MASK_WORDS);
   assign load_addr   = AW'(req_tdata[3:0]);
   assign req_tready  = engine_idle;

   pibm_mask_store #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_mask_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_tdata[67:4]),
      .rd_addr (mask_addr),
      .rd_data (mask_word)
   );

   pibm_bit_engine #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_bit_engine (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_accept),
      .item_op      (req_tuser),
      .item_payload (req_tdata[67:4]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mask_word    (mask_word),
      .mask_addr    (mask_addr),
      .out_busy     (out_busy),
      .emit         (emit),
      .idle         (engine_idle)
   );

   pibm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .busy       (out_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: hdl/pibm_mask_store.sv
// Frozen-position mask memory with per-word valid bits and a registered read port.
// Depends on pibm_pkg.
`default_nettype none

module pibm_mask_store #(
   parameter int MAX_LENGTH = 1024,
   localparam int MASK_WORDS = MAX_LENGTH / pibm_pkg::WORD_BITS,
   localparam int AW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [pibm_pkg::WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output logic [pibm_pkg::WORD_BITS-1:0] rd_data
);
   import pibm_pkg::*;

   logic [WORD_BITS-1:0]  mem_ff [MASK_WORDS];
   logic [MASK_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0]  rd_word_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // A word that was never loaded reads as all information positions.
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

// File: hdl/pibm_out_reg.sv
// Result output register that holds one item until the consumer takes it.
// Depends on pibm_pkg.
`default_nettype none

module pibm_out_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  pibm_pkg::rsp_emit_type         emit,
   output logic                           busy,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pibm_pkg::WORD_BITS-1:0] rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import pibm_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 kind_ff;
   logic [WORD_BITS-1:0] data_ff;
   logic                 last_ff;

   assign busy = valid_ff && !rsp_tready;

   always_comb begin
      if (emit.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         kind_ff <= emit.kind;
         data_ff <= emit.data;
         last_ff <= emit.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// File: hdl/pibm_bit_engine.sv
// Bit-serial mapping engine: walks one codeword position per cycle for insert and extract
// unless a result waits. Holds configuration registers and block counters; needs pibm_pkg.
`default_nettype none

module pibm_bit_engine #(
   parameter int MAX_LENGTH = 1024,
   localparam int MASK_WORDS = MAX_LENGTH / pibm_pkg::WORD_BITS,
   localparam int AW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   input  logic [1:0]                     item_op,
   input  logic [pibm_pkg::WORD_BITS-1:0] item_payload,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [pibm_pkg::CFG_W-1:0]     csr_wdata,
   input  logic [pibm_pkg::WORD_BITS-1:0] mask_word,
   output logic [AW-1:0]                  mask_addr,
   input  logic                           out_busy,
   output pibm_pkg::rsp_emit_type         emit,
   output logic                           idle
);
   import pibm_pkg::*;

   localparam int PW = $clog2(MAX_LENGTH + 1);
   localparam int CW = (PW > CFG_W) ? PW : CFG_W;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_INSERT  = 2'd1;
   localparam logic [1:0] ST_FLUSH   = 2'd2;
   localparam logic [1:0] ST_EXTRACT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [PW-1:0]        info_ff, info_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [WORD_BITS-1:0] xword_ff, xword_in;
   logic [7:0]           byte_ff, byte_in;
   logic [7:0]           bits_ff, bits_in;
   logic [2:0]           fill_ff, fill_in;
   logic [3:0]           left_ff, left_in;
   logic [CFG_W-1:0]     code_length_ff, code_length_in;
   logic [CFG_W-1:0]     info_bits_ff, info_bits_in;

   logic [CW-1:0]        length_trim, length_sat, info_sat;
   logic [PW-1:0]        eff_n, eff_k, pos_next, info_next;
   logic [5:0]           pos_bit;
   logic                 frozen, at_end, at_boundary, block_done, put_value, take_bit;
   logic [WORD_BITS-1:0] word_set;
   logic [7:0]           byte_set;
   rsp_emit_type         emit_c;

   always_comb begin
      length_trim = CW'(code_length_ff) & ~CW'(7);
      if (length_trim > CW'(MAX_LENGTH)) begin
         length_sat = CW'(MAX_LENGTH);
      end else if (length_trim < CW'(8)) begin
         length_sat = CW'(8);
      end else begin
         length_sat = length_trim;
      end
      info_sat = (CW'(info_bits_ff) > length_sat) ? length_sat : CW'(info_bits_ff);
   end

   assign eff_n = PW'(length_sat);
   assign eff_k = PW'(info_sat);

   assign pos_bit     = pos_ff[5:0];
   assign frozen      = mask_word[~pos_bit];
   assign pos_next    = pos_ff + PW'(1);
   assign info_next   = info_ff + PW'(1);
   assign at_end      = pos_next >= eff_n;
   assign at_boundary = pos_next[5:0] == 6'd0;
   assign block_done  = (info_ff >= eff_k) || (pos_ff >= eff_n);
   assign put_value   = (state_ff == ST_INSERT) && !frozen && bits_ff[7];
   assign take_bit    = !frozen && (info_ff < eff_k);
   assign word_set    = word_ff | (WORD_BITS'(put_value) << ~pos_bit);
   assign byte_set    = byte_ff | (8'(xword_ff[~pos_bit]) << ~fill_ff);

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      info_in        = info_ff;
      word_in        = word_ff;
      xword_in       = xword_ff;
      byte_in        = byte_ff;
      bits_in        = bits_ff;
      fill_in        = fill_ff;
      left_in        = left_ff;
      code_length_in = code_length_ff;
      info_bits_in   = info_bits_ff;
      emit_c         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               case (item_op)
                  OP_INSERT: begin
                     bits_in  = item_payload[7:0];
                     left_in  = 4'd8;
                     state_in = ST_INSERT;
                  end
                  OP_EXTRACT: begin
                     xword_in = item_payload;
                     state_in = ST_EXTRACT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INSERT: begin
            if (block_done) begin
               state_in = ST_FLUSH;
            end else if (left_ff == 4'd0) begin
               state_in = ST_IDLE;
            end else begin
               pos_in  = pos_next;
               word_in = word_set;
               if (!frozen) begin
                  bits_in = {bits_ff[6:0], 1'b0};
                  left_in = left_ff - 4'd1;
                  info_in = info_next;
               end
               if (at_boundary || at_end) begin
                  emit_c.valid = 1'b1;
                  emit_c.kind  = RSP_KIND_WORD;
                  emit_c.data  = word_set;
                  emit_c.last  = at_end;
                  word_in      = '0;
               end
            end
         end
         ST_FLUSH: begin
            if (pos_ff < eff_n) begin
               pos_in  = pos_next;
               word_in = word_set;
               if (at_boundary || at_end) begin
                  emit_c.valid = 1'b1;
                  emit_c.kind  = RSP_KIND_WORD;
                  emit_c.data  = word_set;
                  emit_c.last  = at_end;
                  word_in      = '0;
               end
            end else begin
               pos_in   = '0;
               info_in  = '0;
               word_in  = '0;
               byte_in  = '0;
               fill_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_EXTRACT: begin
            pos_in = pos_next;
            if (take_bit) begin
               info_in = info_next;
               if (fill_ff == 3'd7) begin
                  emit_c.valid = 1'b1;
                  emit_c.kind  = RSP_KIND_BYTE;
                  emit_c.data  = WORD_BITS'(byte_set);
                  emit_c.last  = info_next == eff_k;
                  byte_in      = '0;
                  fill_in      = '0;
               end else begin
                  byte_in = byte_set;
                  fill_in = fill_ff + 3'd1;
               end
            end
            if (at_end) begin
               // A partial byte left at the end of the codeword goes out zero-padded.
               if (fill_in != 3'd0) begin
                  emit_c.valid = 1'b1;
                  emit_c.kind  = RSP_KIND_BYTE;
                  emit_c.data  = WORD_BITS'(byte_in);
                  emit_c.last  = 1'b1;
               end
               pos_in   = '0;
               info_in  = '0;
               word_in  = '0;
               byte_in  = '0;
               fill_in  = '0;
               state_in = ST_IDLE;
            end else if (at_boundary) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A result that cannot be placed holds back the whole step until the output can take it.
      if (emit_c.valid && out_busy) begin
         state_in     = state_ff;
         pos_in       = pos_ff;
         info_in      = info_ff;
         word_in      = word_ff;
         xword_in     = xword_ff;
         byte_in      = byte_ff;
         bits_in      = bits_ff;
         fill_in      = fill_ff;
         left_in      = left_ff;
         emit_c.valid = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            REG_CODE_LENGTH: code_length_in = csr_wdata;
            REG_INFO_BITS:   info_bits_in   = csr_wdata;
            default: begin
            end
         endcase
         pos_in  = '0;
         info_in = '0;
         word_in = '0;
         byte_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         info_ff        <= '0;
         word_ff        <= '0;
         byte_ff        <= '0;
         fill_ff        <= '0;
         code_length_ff <= CFG_RESET_LENGTH;
         info_bits_ff   <= CFG_RESET_INFO;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         info_ff        <= info_in;
         word_ff        <= word_in;
         byte_ff        <= byte_in;
         fill_ff        <= fill_in;
         code_length_ff <= code_length_in;
         info_bits_ff   <= info_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      xword_ff <= xword_in;
      bits_ff  <= bits_in;
      left_ff  <= left_in;
   end

   assign mask_addr = pos_in[6 +: AW];
   assign emit      = emit_c;
   assign idle      = state_ff == ST_IDLE;

endmodule

`default_nettype wire

// File: hdl/pibm_checker.sv
// Port-level checks of the polar information bit mapper, bound to the top level.
// Depends on pibm_pkg and polar_info_bit_mapper_core_macros.svh.
`default_nettype none
`include "polar_info_bit_mapper_core_macros.svh"

module pibm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [1:0]                     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pibm_pkg::WORD_BITS-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import pibm_pkg::*;

   `PIBM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `PIBM_ASSERT_SAME(a_byte_upper_zero, rsp_tvalid && (rsp_tuser == RSP_KIND_BYTE), rsp_tdata[63:8] == 56'd0)
   `PIBM_ASSERT_NEXT(a_load_stays_ready, req_tvalid && req_tready && (req_tuser == OP_LOAD || req_tuser == OP_NOP), req_tready)
   `PIBM_ASSERT_NEXT(a_walk_busy, req_tvalid && req_tready && (req_tuser == OP_INSERT || req_tuser == OP_EXTRACT), !req_tready)

endmodule

bind polar_info_bit_mapper_core pibm_checker u_checker (.*);

`default_nettype wire

// File: tb/tb_polar_info_bit_mapper_core.sv
// Self-checking testbench for polar_info_bit_mapper_core: frozen-bit insertion and extraction.
// Needs pibm_pkg and the block's RTL; a directed table runs first, then random blocks of items,
// checked item by item against a behavioral mapper written here or a row's expected result.
`default_nettype none

module tb_polar_info_bit_mapper_core;
   import pibm_pkg::*;

   localparam int MASK_WORDS  = 16;
   localparam int MAX_LEN     = 1024;
   localparam int SETTLE_CYC  = 300;
   localparam int STALL_LIMIT = 3000;

   typedef struct packed {
      logic                 kind;
      logic [WORD_BITS-1:0] data;
      logic                 last;
   } mapper_out_type;

   typedef struct packed {
      logic                 is_cfg;
      logic [1:0]           op;
      logic [3:0]           idx;
      logic [WORD_BITS-1:0] payload;
      logic                 typed;
      mapper_out_type       want;
   } stim_row_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = OP_NOP;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [WORD_BITS-1:0]   rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic                   csr_index  = 1'b0;
   logic [CFG_W-1:0]       csr_wdata  = '0;

   polar_info_bit_mapper_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Mapper state mirrored for prediction.
   logic [WORD_BITS-1:0] frozen_words [MASK_WORDS];
   logic [CFG_W-1:0]     cfg_length;
   logic [CFG_W-1:0]     cfg_info;
   int unsigned          pos_count;
   int unsigned          info_count;
   logic [WORD_BITS-1:0] word_acc;
   logic [7:0]           byte_acc;
   int unsigned          byte_fill;

   mapper_out_type pending_outputs [$];
   stim_row_type   directed_rows [$];
   mapper_out_type got;
   mapper_out_type head;
   int          fail_count    = 0;
   int          req_idle_pct  = 0;
   int          rsp_idle_pct  = 0;
   int          stall_cycles  = 0;
   int          quiet_cycles  = 0;
   int          phase_items   = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned eff_length();
      int unsigned n;
      n = cfg_length & 11'h7F8;
      if (n > MAX_LEN) n = MAX_LEN;
      if (n < 8) n = 8;
      return n;
   endfunction

   function automatic int unsigned eff_info();
      int unsigned n;
      n = eff_length();
      return (cfg_info > n) ? n : cfg_info;
   endfunction

   function automatic bit pos_frozen(int unsigned p);
      return frozen_words[(p >> 6) % MASK_WORDS][63 - (p & 63)];
   endfunction

   function automatic void push_output(logic kind, logic [WORD_BITS-1:0] data, logic last);
      mapper_out_type r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      pending_outputs.push_back(r);
   endfunction

   function automatic void clear_block();
      pos_count  = 0;
      info_count = 0;
      word_acc   = '0;
      byte_acc   = '0;
      byte_fill  = 0;
   endfunction

   function automatic void place_bit(logic b, int unsigned n);
      word_acc[63 - (pos_count & 63)] = word_acc[63 - (pos_count & 63)] | b;
      pos_count++;
      if ((pos_count & 63) == 0 || pos_count >= n) begin
         push_output(RSP_KIND_WORD, word_acc, pos_count >= n);
         word_acc = '0;
      end
   endfunction

   function automatic void insert_info_byte(logic [7:0] info);
      int unsigned n;
      int unsigned k;
      int          b;
      n = eff_length();
      k = eff_info();
      for (b = 7; b >= 0; b--) begin
         if (info_count >= k || pos_count >= n) break;
         while (pos_count < n && pos_frozen(pos_count)) place_bit(1'b0, n);
         if (pos_count < n) begin
            place_bit(info[b], n);
            info_count++;
         end
      end
      if (info_count >= k || pos_count >= n) begin
         while (pos_count < n) place_bit(1'b0, n);
         clear_block();
      end
   endfunction

   function automatic void extract_code_word(logic [WORD_BITS-1:0] word);
      int unsigned n;
      int unsigned k;
      n = eff_length();
      k = eff_info();
      do begin
         if (!pos_frozen(pos_count) && info_count < k) begin
            byte_acc[7 - (byte_fill & 7)] = byte_acc[7 - (byte_fill & 7)]
                                            | word[63 - (pos_count & 63)];
            byte_fill++;
            info_count++;
            if (byte_fill >= 8) begin
               push_output(RSP_KIND_BYTE, {56'd0, byte_acc}, info_count == k);
               byte_acc  = '0;
               byte_fill = 0;
            end
         end
         pos_count++;
      end while (pos_count < n && (pos_count & 63) != 0);
      if (pos_count >= n) begin
         if (byte_fill > 0) push_output(RSP_KIND_BYTE, {56'd0, byte_acc}, 1'b1);
         clear_block();
      end
   endfunction

   function automatic void map_request(logic [1:0] op, logic [3:0] idx,
                                       logic [WORD_BITS-1:0] payload);
      case (op)
         OP_LOAD:    frozen_words[idx] = payload;
         OP_INSERT:  insert_info_byte(payload[7:0]);
         OP_EXTRACT: extract_code_word(payload);
         default: ;
      endcase
   endfunction

   function automatic void add_row(logic is_cfg, logic [1:0] op, logic [3:0] idx,
                                   logic [WORD_BITS-1:0] payload, logic typed,
                                   logic kind, logic [WORD_BITS-1:0] data, logic last);
      stim_row_type r;
      r.is_cfg    = is_cfg;
      r.op        = op;
      r.idx       = idx;
      r.payload   = payload;
      r.typed     = typed;
      r.want.kind = kind;
      r.want.data = data;
      r.want.last = last;
      directed_rows.push_back(r);
   endfunction

   function automatic logic [WORD_BITS-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [WORD_BITS-1:0] random_mask();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return random_word();
         default: return random_word() & random_word() & random_word();
      endcase
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                            input logic [WORD_BITS-1:0] payload,
                            input logic typed, input mapper_out_type want);
      int unsigned queued;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, payload, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      queued = pending_outputs.size();
      map_request(op, idx, payload);
      if (typed) begin
         while (pending_outputs.size() > queued) void'(pending_outputs.pop_back());
         pending_outputs.push_back(want);
      end
      if (op != OP_NOP) phase_items++;
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_CODE_LENGTH) cfg_length = value;
      else cfg_info = value;
      clear_block();
   endtask

   task automatic run_random_block();
      int unsigned choice;
      int unsigned loads;
      int unsigned i;
      logic [3:0]  idx;
      choice = $urandom_range(99);
      if ($urandom_range(1)) begin
         loads = $urandom_range(1, 3);
         for (i = 0; i < loads; i++) begin
            if ($urandom_range(3) == 0) idx = 4'($urandom_range(15));
            else idx = 4'($urandom_range(0, (eff_length() - 1) >> 6));
            send_item(OP_LOAD, idx, random_mask(), 1'b0, '0);
         end
      end
      if (choice < 45) begin
         do send_item(OP_INSERT, 4'($urandom), random_word(), 1'b0, '0);
         while (pos_count != 0);
      end else if (choice < 80) begin
         do send_item(OP_EXTRACT, 4'($urandom), random_word(), 1'b0, '0);
         while (pos_count != 0);
      end else if (choice < 90) begin
         do send_item($urandom_range(1) ? OP_INSERT : OP_EXTRACT, 4'($urandom),
                      random_word(), 1'b0, '0);
         while (pos_count != 0);
      end else begin
         loads = $urandom_range(1, 4);
         for (i = 0; i < loads; i++)
            send_item(2'($urandom_range(3)), 4'($urandom), random_word(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         stall_cycles = stall_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.data = rsp_tdata;
         got.last = rsp_tlast;
         if (pending_outputs.size() == 0) begin
            $error("unexpected item: kind %0d data %h last %0d", got.kind, got.data, got.last);
            fail_count++;
         end else begin
            head = pending_outputs.pop_front();
            if (got.kind !== head.kind) begin
               $error("result_kind expected %0d actual %0d", head.kind, got.kind);
               fail_count++;
            end
            if (got.data !== head.data) begin
               $error("result_data expected %h actual %h", head.data, got.data);
               fail_count++;
            end
            if (got.last !== head.last) begin
               $error("end_of_block expected %0d actual %0d", head.last, got.last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int          phase;
      int unsigned n;
      for (int i = 0; i < MASK_WORDS; i++) frozen_words[i] = '0;
      cfg_length = CFG_RESET_LENGTH;
      cfg_info   = CFG_RESET_INFO;
      clear_block();

      // Register rows carry the register index in idx and the value in payload.
      add_row(0, OP_INSERT,  0,  64'hFF, 0, 0, 0, 0);
      add_row(0, OP_NOP,     15, '1, 0, 0, 0, 0);
      add_row(0, OP_EXTRACT, 0,  64'h8000_0000_0000_0001, 0, 0, 0, 0);
      add_row(1, OP_NOP, REG_CODE_LENGTH, 64'd8, 0, 0, 0, 0);
      add_row(1, OP_NOP, REG_INFO_BITS,   64'd8, 0, 0, 0, 0);
      add_row(0, OP_INSERT,  0, 64'hA5, 1, RSP_KIND_WORD, 64'hA500_0000_0000_0000, 1);
      add_row(0, OP_EXTRACT, 0, '1, 1, RSP_KIND_BYTE, 64'hFF, 1);
      add_row(1, OP_NOP, REG_INFO_BITS, 64'd0, 0, 0, 0, 0);
      add_row(0, OP_INSERT,  0, 64'h5A, 1, RSP_KIND_WORD, 64'h0, 1);
      add_row(0, OP_EXTRACT, 0, '1, 0, 0, 0, 0);
      add_row(1, OP_NOP, REG_CODE_LENGTH, 64'd2047, 0, 0, 0, 0);
      add_row(1, OP_NOP, REG_INFO_BITS,   64'd2047, 0, 0, 0, 0);
      add_row(0, OP_LOAD,    0, '1, 0, 0, 0, 0);
      add_row(0, OP_INSERT,  0, 64'h00, 1, RSP_KIND_WORD, 64'h0, 0);
      add_row(0, OP_LOAD,    1, 64'h00FF_0000_0000_0000, 0, 0, 0, 0);
      add_row(0, OP_INSERT,  0, 64'hC3, 0, 0, 0, 0);
      add_row(0, OP_EXTRACT, 0, 64'h1234_5678_9ABC_DEF0, 0, 0, 0, 0);
      add_row(1, OP_NOP, REG_CODE_LENGTH, 64'd12, 0, 0, 0, 0);
      add_row(1, OP_NOP, REG_INFO_BITS,   64'd3, 0, 0, 0, 0);
      add_row(0, OP_INSERT,  0, 64'hE0, 1, RSP_KIND_WORD, 64'h0, 1);
      add_row(0, OP_LOAD,    0, 64'h5000_0000_0000_0000, 0, 0, 0, 0);
      add_row(0, OP_INSERT,  0, 64'hFF, 1, RSP_KIND_WORD, 64'hA800_0000_0000_0000, 1);
      add_row(0, OP_EXTRACT, 0, '1, 1, RSP_KIND_BYTE, 64'hE0, 1);
      add_row(1, OP_NOP, REG_CODE_LENGTH, 64'd72, 0, 0, 0, 0);
      add_row(1, OP_NOP, REG_INFO_BITS,   64'd1024, 0, 0, 0, 0);
      add_row(0, OP_EXTRACT, 0, '1, 0, 0, 0, 0);
      add_row(0, OP_EXTRACT, 0, 64'hFF00_0000_0000_0000, 0, 0, 0, 0);
      add_row(0, OP_LOAD,    15, '1, 0, 0, 0, 0);
      add_row(0, OP_INSERT,  0, 64'h81, 0, 0, 0, 0);
      add_row(0, OP_LOAD,    0, 64'h0, 0, 0, 0, 0);
      add_row(0, OP_LOAD,    1, 64'h0, 0, 0, 0, 0);
      add_row(0, OP_LOAD,    15, 64'h0, 0, 0, 0, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 33;
      rsp_idle_pct = 60;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_cfg) begin
            settle_block();
            write_reg(directed_rows[r].idx[0], directed_rows[r].payload[CFG_W-1:0]);
         end else begin
            send_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].payload,
                      directed_rows[r].typed, directed_rows[r].want);
         end
      end

      for (phase = 0; phase < 6; phase++) begin
         settle_block();
         req_idle_pct = (phase < 2) ? 33 : (phase < 4) ? 60 : 0;
         rsp_idle_pct = (phase < 2) ? 60 : (phase < 4) ? 33 : 0;
         case (phase)
            0: begin
               n = 8 * $urandom_range(1, 16);
               write_reg(REG_CODE_LENGTH, CFG_W'(n));
               write_reg(REG_INFO_BITS, CFG_W'($urandom_range(0, n)));
            end
            1: begin
               write_reg(REG_CODE_LENGTH, 11'd1024);
               write_reg(REG_INFO_BITS, CFG_W'($urandom_range(0, 48)));
            end
            2: begin
               write_reg(REG_CODE_LENGTH, 11'd8);
               write_reg(REG_INFO_BITS, 11'd8);
            end
            3: begin
               write_reg(REG_CODE_LENGTH, CFG_W'($urandom_range(8, 256)));
               write_reg(REG_INFO_BITS, CFG_W'($urandom_range(0, 300)));
            end
            4: begin
               write_reg(REG_CODE_LENGTH, 11'd64);
               write_reg(REG_INFO_BITS, 11'd64);
               stall_cycles = 400;
            end
            default: begin
               write_reg(REG_CODE_LENGTH, 11'd136);
               write_reg(REG_INFO_BITS, 11'd2047);
            end
         endcase
         phase_items = 0;
         while (phase_items < 38) run_random_block();
      end

      settle_block();
      if (fail_count == 0 && pending_outputs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
